[src/ede_pkg.sv]
// Shared types and constants for the edit distance engine.
package ede_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int CMD_W       = 2;
  localparam int SYM_W       = 8;
  localparam int DIST_W      = 7;

  localparam logic [CMD_W-1:0]  CMD_FIRST   = 2'd0;
  localparam logic [CMD_W-1:0]  CMD_SECOND  = 2'd1;
  localparam logic [CMD_W-1:0]  CMD_COMPUTE = 2'd2;
  localparam logic [DIST_W-1:0] DIST_MAX    = 7'd127;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } out_item_t;

  // Per-cycle controls broadcast to every cell.
  typedef struct packed {
    logic init;   // load the first-row cost
    logic clear;  // drop the second string
    logic load;   // write a byte into the addressed cell
  } cell_ctl_t;

endpackage

[src/edit_distance_engine_top.sv]
// Levenshtein edit distance engine: top level with sequencer, byte store and cell chain.
// Edit distance between two byte strings of up to MAX_LEN bytes each.
// Appends (cmd 0 to the first string, cmd 1 to the second) are taken
// only while no compute runs. The second string lives in a chain of
// MAX_LEN cells, one byte and one column cost per cell; the first string
// sits in a RAM. A compute item launches one row of the DP per cycle into
// the chain; each row walks the chain as a diagonal wavefront, one cell
// per cycle. Between the compute item and its result lie a setup state,
// one RAM read per row of the first string, the hops of every row through
// every cell (each row runs to the last cell) and a register for the
// result. If either string is empty the result is valid on the next
// cycle. The result is held in an output register; appends are still
// taken while it waits, but a compute item waits until the result is
// taken, and no item is taken while a compute runs. Appends past MAX_LEN
// are dropped and flagged in the overflow bit; distances above 127
// saturate. Both lengths and the overflow flag clear once the result is
// produced.
module edit_distance_engine_top #(
  parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ede_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ede_pkg::out_item_t out_data
);
  import ede_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_INIT  = 4'b0010,
    S_FEED  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [LW-1:0]   first_len_r, first_len_nxt;
  logic [LW-1:0]   second_len_r, second_len_nxt;
  logic            dropped_r, dropped_nxt;
  logic [LW-1:0]   row_r, row_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic            inj_valid_r;
  logic            inj_last_r;
  logic [LW-1:0]   inj_row_r;

  logic            acc_in;
  logic            first_wr;
  logic            rd_en;
  logic [SYM_W-1:0] rd_sym;
  cell_ctl_t       ctl;

  logic             c_valid [0:MAX_LEN];
  logic             c_last  [0:MAX_LEN];
  logic [SYM_W-1:0] c_sym   [0:MAX_LEN];
  logic [LW-1:0]    c_new   [0:MAX_LEN];
  logic [LW-1:0]    c_old   [0:MAX_LEN];

  function automatic logic [DIST_W-1:0] sat_dist(input logic [LW-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    return (ext > 32'(DIST_MAX)) ? DIST_MAX : ext[DIST_W-1:0];
  endfunction

  // a waiting result only holds back a compute item; appends keep flowing
  assign in_ready = (state_r == S_IDLE) && !(out_valid_r && (in_data.cmd == CMD_COMPUTE));
  assign acc_in   = in_valid && in_ready;
  assign first_wr = acc_in && (in_data.cmd == CMD_FIRST) && (first_len_r < LW'(MAX_LEN));
  assign rd_en    = (state_r == S_FEED);

  // First string store, read one row byte per cycle while feeding
  ede_ram #(
    .W     (SYM_W),
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_first_ram (
    .clk     (clk),
    .wr_en   (first_wr),
    .wr_addr (first_len_r[AW-1:0]),
    .wr_data (in_data.symbol),
    .rd_en   (rd_en),
    .rd_addr (row_r[AW-1:0]),
    .rd_data (rd_sym)
  );

  // Column zero of the DP: D[i][0] = i, D[i-1][0] = i - 1
  assign c_valid[0] = inj_valid_r;
  assign c_last[0]  = inj_last_r;
  assign c_sym[0]   = rd_sym;
  assign c_new[0]   = inj_row_r;
  assign c_old[0]   = inj_row_r - LW'(1);

  for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
    ede_cell #(
      .LW  (LW),
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .ld_sym  (in_data.symbol),
      .ld_idx  (second_len_r),
      .l_valid (c_valid[g-1]),
      .l_last  (c_last[g-1]),
      .l_sym   (c_sym[g-1]),
      .l_new   (c_new[g-1]),
      .l_old   (c_old[g-1]),
      .r_valid (c_valid[g]),
      .r_last  (c_last[g]),
      .r_sym   (c_sym[g]),
      .r_new   (c_new[g]),
      .r_old   (c_old[g])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    first_len_nxt  = first_len_r;
    second_len_nxt = second_len_r;
    dropped_nxt    = dropped_r;
    row_nxt        = row_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ctl            = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          if (in_data.cmd == CMD_FIRST) begin
            if (first_len_r < LW'(MAX_LEN)) begin
              first_len_nxt = first_len_r + LW'(1);
            end else begin
              dropped_nxt = 1'b1;
            end
          end else if (in_data.cmd == CMD_SECOND) begin
            if (second_len_r < LW'(MAX_LEN)) begin
              ctl.load       = 1'b1;
              second_len_nxt = second_len_r + LW'(1);
            end else begin
              dropped_nxt = 1'b1;
            end
          end else if (in_data.cmd == CMD_COMPUTE) begin
            if (first_len_r == '0 || second_len_r == '0) begin
              // empty string: distance is the other length
              out_valid_nxt         = 1'b1;
              out_data_nxt.distance = sat_dist(first_len_r | second_len_r);
              out_data_nxt.overflow = dropped_r;
              first_len_nxt         = '0;
              second_len_nxt        = '0;
              dropped_nxt           = 1'b0;
              ctl.clear             = 1'b1;
            end else begin
              state_nxt = S_INIT;
            end
          end
        end
      end
      S_INIT: begin
        ctl.init  = 1'b1;
        row_nxt   = '0;
        state_nxt = S_FEED;
      end
      S_FEED: begin
        row_nxt = row_r + LW'(1);
        if (row_r == first_len_r - LW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (c_valid[MAX_LEN] && c_last[MAX_LEN]) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.distance = sat_dist(c_new[MAX_LEN]);
          out_data_nxt.overflow = dropped_r;
          first_len_nxt         = '0;
          second_len_nxt        = '0;
          dropped_nxt           = 1'b0;
          ctl.clear             = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_len_r  <= '0;
      second_len_r <= '0;
      dropped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      inj_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_len_r  <= first_len_nxt;
      second_len_r <= second_len_nxt;
      dropped_r    <= dropped_nxt;
      out_valid_r  <= out_valid_nxt;
      inj_valid_r  <= rd_en;
    end
  end

  // RAM read data lands in the cycle after the address; row tags are registered alongside it
  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    out_data_r <= out_data_nxt;
    inj_row_r  <= row_r + LW'(1);
    inj_last_r <= (row_r == first_len_r - LW'(1));
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/ede_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ede_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [0:DEPTH-1];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/ede_cell.sv]
// One column cell of the edit distance array: holds a second-string byte and its cost.
module ede_cell #(
  parameter int LW  = 7,
  parameter int IDX = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ede_pkg::cell_ctl_t                ctl,
  input  logic [ede_pkg::SYM_W-1:0]         ld_sym,
  input  logic [LW-1:0]                     ld_idx,
  input  logic                              l_valid,
  input  logic                              l_last,
  input  logic [ede_pkg::SYM_W-1:0]         l_sym,
  input  logic [LW-1:0]                     l_new,
  input  logic [LW-1:0]                     l_old,
  output logic                              r_valid,
  output logic                              r_last,
  output logic [ede_pkg::SYM_W-1:0]         r_sym,
  output logic [LW-1:0]                     r_new,
  output logic [LW-1:0]                     r_old
);
  import ede_pkg::*;

  logic             active_r;
  logic [SYM_W-1:0] sym_r;
  logic [LW-1:0]    cost_r;
  logic             r_valid_r;
  logic             r_last_r;
  logic [SYM_W-1:0] r_sym_r;
  logic [LW-1:0]    r_new_r;
  logic [LW-1:0]    r_old_r;

  logic          hit;
  logic [LW-1:0] min_a;
  logic [LW-1:0] min_b;
  logic [LW-1:0] cost_nxt;

  assign hit = ctl.load && (ld_idx == LW'(IDX - 1));

  always_comb begin
    min_a    = (cost_r < l_old) ? cost_r : l_old;
    min_b    = (min_a < l_new) ? min_a : l_new;
    cost_nxt = (l_sym == sym_r) ? l_old : min_b + LW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      r_valid_r <= 1'b0;
    end else begin
      r_valid_r <= l_valid;
      if (ctl.clear) begin
        active_r <= 1'b0;
      end else if (hit) begin
        active_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      sym_r <= ld_sym;
    end
    if (ctl.init) begin
      cost_r <= LW'(IDX);
    end else if (l_valid && active_r) begin
      cost_r <= cost_nxt;
    end
    r_last_r <= l_last;
    r_sym_r  <= l_sym;
    // inactive cells past the string end pass the wavefront through
    r_new_r  <= active_r ? cost_nxt : l_new;
    r_old_r  <= cost_r;
  end

  assign r_valid = r_valid_r;
  assign r_last  = r_last_r;
  assign r_sym   = r_sym_r;
  assign r_new   = r_new_r;
  assign r_old   = r_old_r;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for edit_distance_engine_top: random string pairs, scoreboard, stalls.
module testbench;
  import ede_pkg::*;

  localparam int STR_CAP    = MAX_LEN_DEF;
  localparam int IDLE_LIMIT = 50000;  // cycles with no handshake on either side
  localparam int LONG_HOLD  = 900;    // receiver hold-off, enough to back up the input
  localparam int DRAIN_TAIL = 300;    // quiet cycles after the last result
  localparam int ITEM_GOAL  = 1900;
  localparam int REPORT_MAX = 10;

  // cmd 3 has no meaning in the block; used as noise
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    in_item_t item;
    bit       wait_idle;  // hold this item back until every result is in
  } cmd_slot_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  cmd_slot_t cmd_q[$];       // items not yet offered to the block
  out_item_t distance_q[$];  // predicted results, oldest first

  // Predictor state: the two strings and the dropped-byte flag.
  logic [SYM_W-1:0] str_a[STR_CAP];
  logic [SYM_W-1:0] str_b[STR_CAP];
  int               len_a;
  int               len_b;
  bit               bytes_lost;

  int errors;
  int idle_cycles;
  int n_items;

  // Sender burst shaping
  int burst_left;
  int gap_left;

  // Receiver state
  logic [31:0] rx_tick;
  int          hold_left;
  int          taken;

  edit_distance_engine_top #(.MAX_LEN(STR_CAP)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bottom-up Levenshtein over a single cost row; saturates at the field max.
  function automatic int levenshtein();
    int row[0:STR_CAP];
    int i;
    int j;
    int diag;
    int up;
    int best;
    for (j = 0; j <= len_b; j++) row[j] = j;
    for (i = 1; i <= len_a; i++) begin
      diag = row[0];
      row[0] = i;
      for (j = 1; j <= len_b; j++) begin
        up = row[j];
        if (str_a[i-1] == str_b[j-1]) begin
          row[j] = diag;
        end else begin
          best = (up < diag) ? up : diag;
          if (row[j-1] < best) best = row[j-1];
          row[j] = best + 1;
        end
        diag = up;
      end
    end
    return (row[len_b] > int'(DIST_MAX)) ? int'(DIST_MAX) : row[len_b];
  endfunction

  // Apply one accepted item to the predictor; a compute queues its result.
  task automatic absorb_cmd(input in_item_t it);
    out_item_t r;
    case (it.cmd)
      CMD_FIRST: begin
        if (len_a < STR_CAP) begin
          str_a[len_a] = it.symbol;
          len_a++;
        end else begin
          bytes_lost = 1'b1;
        end
      end
      CMD_SECOND: begin
        if (len_b < STR_CAP) begin
          str_b[len_b] = it.symbol;
          len_b++;
        end else begin
          bytes_lost = 1'b1;
        end
      end
      CMD_COMPUTE: begin
        r.distance = DIST_W'(levenshtein());
        r.overflow = bytes_lost;
        distance_q.insert(distance_q.size(), r);
        len_a = 0;
        len_b = 0;
        bytes_lost = 1'b0;
      end
      default: ;  // unused command: no effect
    endcase
  endtask

  task automatic add_cmd(input logic [CMD_W-1:0] c, input logic [SYM_W-1:0] s,
                         input bit hold);
    cmd_slot_t slot;
    slot.item.cmd = c;
    slot.item.symbol = s;
    slot.wait_idle = hold;
    cmd_q.insert(cmd_q.size(), slot);
    if (c != CMD_UNUSED) n_items++;
  endtask

  // One random string pair followed by its compute.
  task automatic queue_pair(input bit hold_first);
    logic [SYM_W-1:0] a_buf[$];
    logic [SYM_W-1:0] b_buf[$];
    logic [SYM_W-1:0] alpha[4];
    int na;
    int nb;
    int sel;
    int kind;
    int k;
    int r;
    int ia;
    int ib;
    int tmp;
    bit hold;
    bit pick_a;
    sel = $urandom_range(0, 99);
    if (sel < 58) begin
      na = $urandom_range(0, 8);
      nb = $urandom_range(0, 8);
    end else if (sel < 82) begin
      na = $urandom_range(9, 24);
      nb = $urandom_range(9, 24);
    end else if (sel < 92) begin
      na = $urandom_range(25, STR_CAP);
      nb = $urandom_range(25, STR_CAP);
      if ($urandom_range(0, 3) == 0) begin
        na = STR_CAP;
        nb = STR_CAP;
      end
    end else begin
      // overrun one side (sometimes both) past capacity
      na = $urandom_range(0, STR_CAP + 6);
      nb = STR_CAP + $urandom_range(1, 6);
      if ($urandom_range(0, 1) == 1) begin
        tmp = na;
        na = nb;
        nb = tmp;
      end
    end
    kind = $urandom_range(0, 9);
    for (k = 0; k < 4; k++) alpha[k] = SYM_W'($urandom_range(0, 255));
    // small alphabet gives many matching bytes; otherwise full range
    for (k = 0; k < na; k++)
      a_buf.insert(a_buf.size(),
                   kind < 5 ? alpha[$urandom_range(0, 3)] : SYM_W'($urandom_range(0, 255)));
    if (kind >= 5 && kind < 7) begin
      // second string is a lightly edited copy of the first
      for (k = 0; k < na; k++) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          b_buf.insert(b_buf.size(), a_buf[k]);
        end else if (r == 7) begin
          b_buf.insert(b_buf.size(), SYM_W'($urandom_range(0, 255)));
        end else if (r == 9) begin
          b_buf.insert(b_buf.size(), a_buf[k]);
          b_buf.insert(b_buf.size(), SYM_W'($urandom_range(0, 255)));
        end
      end
    end else begin
      for (k = 0; k < nb; k++)
        b_buf.insert(b_buf.size(),
                     kind < 5 ? alpha[$urandom_range(0, 3)] : SYM_W'($urandom_range(0, 255)));
    end
    hold = hold_first;
    ia = 0;
    ib = 0;
    while (ia < a_buf.size() || ib < b_buf.size()) begin
      if ($urandom_range(0, 31) == 0) begin
        add_cmd(CMD_UNUSED, SYM_W'($urandom_range(0, 255)), hold);
        hold = 1'b0;
      end
      pick_a = (ia < a_buf.size()) && (ib >= b_buf.size() || $urandom_range(0, 1) == 1);
      if (pick_a) begin
        add_cmd(CMD_FIRST, a_buf[ia], hold);
        ia++;
      end else begin
        add_cmd(CMD_SECOND, b_buf[ib], hold);
        ib++;
      end
      hold = 1'b0;
    end
    add_cmd(CMD_COMPUTE, SYM_W'($urandom_range(0, 255)), hold);
  endtask

  // Stimulus build, reset, and end of run.
  initial begin
    int pairs;
    errors = 0;
    n_items = 0;
    len_a = 0;
    len_b = 0;
    bytes_lost = 1'b0;

    // Directed: empty pair, one side empty, symbol extremes, ignored command.
    add_cmd(CMD_COMPUTE, 8'h00, 1'b0);
    add_cmd(CMD_FIRST, 8'h00, 1'b0);
    add_cmd(CMD_FIRST, 8'hFF, 1'b0);
    add_cmd(CMD_COMPUTE, 8'h00, 1'b0);
    add_cmd(CMD_SECOND, 8'hFF, 1'b0);
    add_cmd(CMD_SECOND, 8'h00, 1'b0);
    add_cmd(CMD_SECOND, 8'h5A, 1'b0);
    add_cmd(CMD_COMPUTE, 8'hFF, 1'b0);
    add_cmd(CMD_FIRST, 8'h12, 1'b0);
    add_cmd(CMD_SECOND, 8'h12, 1'b0);
    add_cmd(CMD_UNUSED, 8'hA5, 1'b0);   // must not append or compute
    add_cmd(CMD_UNUSED, 8'h5A, 1'b0);
    add_cmd(CMD_COMPUTE, 8'h80, 1'b0);
    add_cmd(CMD_FIRST, 8'h00, 1'b0);
    add_cmd(CMD_FIRST, 8'hFF, 1'b0);
    add_cmd(CMD_FIRST, 8'h80, 1'b0);
    add_cmd(CMD_SECOND, 8'hFF, 1'b0);
    add_cmd(CMD_SECOND, 8'h00, 1'b0);
    add_cmd(CMD_SECOND, 8'h80, 1'b0);
    add_cmd(CMD_COMPUTE, 8'h7F, 1'b0);

    // Random pairs; a few wait for the block to go fully idle first.
    pairs = 0;
    while (n_items < ITEM_GOAL) begin
      queue_pair(pairs == 12 || pairs == 40 || pairs == 60);
      pairs++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || in_valid || distance_q.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_TAIL) @(posedge clk);
    if (errors == 0 && distance_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Sender: bursts of items with random gaps; the slot frees on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= $urandom_range(1, 30);
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (cmd_q[0].wait_idle &&
                   (distance_q.size() != 0 || (out_valid && out_ready) ||
                    (in_valid && in_ready))) begin
        // pause until the block has delivered everything owed
        in_valid <= 1'b0;
      end else begin
        in_data <= cmd_q[0].item;
        in_valid <= 1'b1;
        cmd_q.delete(0);
        if (burst_left <= 1) begin
          // occasional long run with no gaps at all
          burst_left <= ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
          gap_left <= $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: rotating stall pattern plus two long hold-offs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_tick <= '0;
      hold_left <= 0;
      taken <= 0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (out_valid && out_ready) taken <= taken + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && (taken == 14 || taken == 44)) begin
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        case (rx_tick[9:8])
          2'd0:    out_ready <= 1'b1;
          2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
          2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor: check the result first, then fold in the accepted item, so a
  // result can never be matched against a prediction made at the same edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (distance_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected result: distance %0d overflow %0d",
                     out_data.distance, out_data.overflow);
        end else begin
          want = distance_q[0];
          distance_q.delete(0);
          if (out_data.distance !== want.distance || out_data.overflow !== want.overflow) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("mismatch: distance exp %0d got %0d, overflow exp %0d got %0d",
                       want.distance, out_data.distance, want.overflow, out_data.overflow);
          end
        end
      end
      if (in_valid && in_ready) absorb_cmd(in_data);

      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule
